// ===== rtl/core/mh3_pkg.sv =====
`timescale 1ns / 1ps

package mh3_pkg;

    localparam logic [31:0] C1       = 32'hcc9e2d51;
    localparam logic [31:0] C2       = 32'h1b873593;
    localparam logic [31:0] FOLD_ADD = 32'he6546b64;
    localparam logic [31:0] FMIX1    = 32'h85ebca6b;
    localparam logic [31:0] FMIX2    = 32'hc2b2ae35;

    localparam int unsigned FULL_BYTES = 4;
    localparam int unsigned QDEPTH     = 2;
    localparam int unsigned QPTR_W     = $clog2(QDEPTH);
    localparam int unsigned QLVL_W     = $clog2(QDEPTH + 1);

    // One classified word as it waits for the back end. The count is already
    // normalized and the word already has its unused tail bytes cleared.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  count;
        logic        last;
    } q_item_t;

    typedef struct packed {
        logic idle;
        logic finishing;
    } back_status_t;

endpackage

// ===== rtl/core/murmur3_32_hash.sv =====
`timescale 1ns / 1ps

// MurmurHash3 x86_32 with a zero seed over a message that arrives as
// little-endian 32-bit words; each request carries one word, its byte count
// and a last-word mark, and the last word of a message produces one hash
// request on the output. Incoming words land in a two-entry queue, so the
// input keeps taking words while the hash core works and while a finished
// hash waits on the output, until the queue is full. The hash core uses one
// shared 32x32 multiplier: a word with data passes pop, two mixing multiplies
// and fold, a last word adds finalization, and a last word with no bytes goes
// from pop straight to finalization. The core pops a new word only when idle.
module murmur3_32_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    input  logic        final_word,
    output logic        hash_valid,
    input  logic        hash_ready,
    output logic [31:0] hash_value
);
    import mh3_pkg::*;

    logic              push;
    q_item_t           push_item;
    logic              queue_full;
    logic              pop;
    q_item_t           pop_item;
    logic              queue_not_empty;
    logic [QLVL_W-1:0] queue_level;
    back_status_t      back_status;

    mh3_front u_front (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .data_word  (data_word),
        .byte_count (byte_count),
        .final_word (final_word),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    mh3_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .not_empty (queue_not_empty),
        .level     (queue_level)
    );

    mh3_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .queue_not_empty (queue_not_empty),
        .pop_item        (pop_item),
        .pop             (pop),
        .hash_valid      (hash_valid),
        .hash_ready      (hash_ready),
        .hash_value      (hash_value),
        .status          (back_status)
    );

    // An accepted request must always find room in the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |-> (queue_level < QLVL_W'(QDEPTH)))
        else $error("request accepted into a full queue");

    // The core only takes a word when it is idle and one is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (queue_not_empty && back_status.idle))
        else $error("queue popped while empty or while the core is busy");

    // A new hash only appears right after the last finalization step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hash_valid) |-> $past(back_status.finishing))
        else $error("hash presented without finalization");

    // A full queue that is not popped keeps its level at the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        (queue_level == QLVL_W'(QDEPTH) && !pop) |=> (queue_level == QLVL_W'(QDEPTH)))
        else $error("queue level changed without a pop");

endmodule

// ===== rtl/core/mh3_front.sv =====
`timescale 1ns / 1ps

module mh3_front (
    input  logic              item_valid,
    output logic              item_ready,
    input  logic [31:0]       data_word,
    input  logic [2:0]        byte_count,
    input  logic              final_word,
    output logic              push,
    output mh3_pkg::q_item_t  push_item,
    input  logic              queue_full
);
    import mh3_pkg::*;

    logic [2:0]  count_norm;
    logic [31:0] byte_mask;

    // A word that is not the last one, or that claims more than four bytes,
    // always counts as a full word.
    always_comb
    begin
        if (!final_word || (byte_count > 3'(FULL_BYTES)))
        begin
            count_norm = 3'(FULL_BYTES);
        end
        else
        begin
            count_norm = byte_count;
        end
    end

    always_comb
    begin
        unique case (count_norm)
            3'd0:    byte_mask = 32'h0000_0000;
            3'd1:    byte_mask = 32'h0000_00ff;
            3'd2:    byte_mask = 32'h0000_ffff;
            3'd3:    byte_mask = 32'h00ff_ffff;
            default: byte_mask = 32'hffff_ffff;
        endcase
    end

    assign item_ready      = !queue_full;
    assign push            = item_valid && !queue_full;
    assign push_item.word  = data_word & byte_mask;
    assign push_item.count = count_norm;
    assign push_item.last  = final_word;

endmodule

// ===== rtl/core/mh3_queue.sv =====
`timescale 1ns / 1ps

module mh3_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  mh3_pkg::q_item_t           push_item,
    output logic                       full,
    input  logic                       pop,
    output mh3_pkg::q_item_t           pop_item,
    output logic                       not_empty,
    output logic [mh3_pkg::QLVL_W-1:0] level
);
    import mh3_pkg::*;

    q_item_t           entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QLVL_W-1:0] level_reg, level_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item  = entry_reg[rd_ptr_reg];
    assign full      = (level_reg == QLVL_W'(QDEPTH));
    assign not_empty = (level_reg != '0);
    assign level     = level_reg;

endmodule

// ===== rtl/core/mh3_back.sv =====
`timescale 1ns / 1ps

module mh3_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  queue_not_empty,
    input  mh3_pkg::q_item_t      pop_item,
    output logic                  pop,
    output logic                  hash_valid,
    input  logic                  hash_ready,
    output logic [31:0]           hash_value,
    output mh3_pkg::back_status_t status
);
    import mh3_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL1 = 7'b0000010,
        ST_MUL2 = 7'b0000100,
        ST_FOLD = 7'b0001000,
        ST_FIN0 = 7'b0010000,
        ST_FIN1 = 7'b0100000,
        ST_FIN2 = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] k_reg, k_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        last_reg, last_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] hash_reg, hash_next;
    logic        hash_valid_reg, hash_valid_next;

    logic [31:0] mul_a, mul_b, prod;
    logic [31:0] fold_x, fold_r, fin_f, fin_g;

    // The single multiplier is shared by both mixing steps and both
    // finalizer steps; the state picks its operands.
    assign prod = mul_a * mul_b;

    assign fold_x = h_reg ^ k_reg;
    assign fold_r = {fold_x[18:0], fold_x[31:19]};
    assign fin_f  = (h_reg ^ len_reg) ^ ((h_reg ^ len_reg) >> 16);
    assign fin_g  = k_reg ^ (k_reg >> 13);

    always_comb
    begin
        unique case (state_reg)
            ST_MUL1:
            begin
                mul_a = k_reg;
                mul_b = C1;
            end
            ST_MUL2:
            begin
                mul_a = {k_reg[16:0], k_reg[31:17]};
                mul_b = C2;
            end
            ST_FIN0:
            begin
                mul_a = fin_f;
                mul_b = FMIX1;
            end
            ST_FIN1:
            begin
                mul_a = fin_g;
                mul_b = FMIX2;
            end
            default:
            begin
                mul_a = k_reg;
                mul_b = C1;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        cnt_next        = cnt_reg;
        last_next       = last_reg;
        h_next          = h_reg;
        len_next        = len_reg;
        hash_next       = hash_reg;
        hash_valid_next = hash_valid_reg && !hash_ready;
        pop             = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (queue_not_empty)
                begin
                    pop       = 1'b1;
                    k_next    = pop_item.word;
                    cnt_next  = pop_item.count;
                    last_next = pop_item.last;
                    // Only a final word can carry no bytes; it goes straight
                    // to finalization.
                    state_next = (pop_item.count == 3'd0) ? ST_FIN0 : ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                k_next     = prod;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                k_next     = prod;
                state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                if (cnt_reg == 3'(FULL_BYTES))
                begin
                    h_next = (fold_r << 2) + fold_r + FOLD_ADD;
                end
                else
                begin
                    h_next = fold_x;
                end
                len_next   = len_reg + {29'd0, cnt_reg};
                state_next = last_reg ? ST_FIN0 : ST_IDLE;
            end
            ST_FIN0:
            begin
                k_next     = prod;
                state_next = ST_FIN1;
            end
            ST_FIN1:
            begin
                k_next     = prod;
                state_next = ST_FIN2;
            end
            ST_FIN2:
            begin
                if (!hash_valid_reg || hash_ready)
                begin
                    hash_next       = k_reg ^ (k_reg >> 16);
                    hash_valid_next = 1'b1;
                    h_next          = '0;
                    len_next        = '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            h_reg          <= '0;
            len_reg        <= '0;
            hash_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            h_reg          <= h_next;
            len_reg        <= len_next;
            hash_valid_reg <= hash_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        cnt_reg  <= cnt_next;
        last_reg <= last_next;
        hash_reg <= hash_next;
    end

    assign hash_valid       = hash_valid_reg;
    assign hash_value       = hash_reg;
    assign status.idle      = (state_reg == ST_IDLE);
    assign status.finishing = (state_reg == ST_FIN2);

endmodule

// ===== tb/tb_murmur3_32_hash.sv =====
`timescale 1ns / 1ps

module tb_murmur3_32_hash;

    localparam logic [31:0] MIX_MUL_A   = 32'hcc9e2d51;
    localparam logic [31:0] MIX_MUL_B   = 32'h1b873593;
    localparam logic [31:0] FOLD_OFFSET = 32'he6546b64;
    localparam logic [31:0] AVAL_MUL_A  = 32'h85ebca6b;
    localparam logic [31:0] AVAL_MUL_B  = 32'hc2b2ae35;

    localparam int DIRECTED_ROWS   = 23;
    localparam int RANDOM_REQUESTS = 1100;
    localparam int DRAIN_CYCLES    = 12;
    localparam int CYCLE_LIMIT     = 400000;

    typedef enum logic {CHK_MODEL, CHK_FIXED} chk_kind_t;
    typedef enum logic [1:0] {RX_STREAM, RX_CHOPPY, RX_SLOW} rx_mode_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  count;
        logic        last;
        chk_kind_t   kind;
        logic [31:0] fixed_hash;
    } dir_row_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic [31:0] data_word  = '0;
    logic [2:0]  byte_count = '0;
    logic        final_word = 1'b0;
    logic        hash_valid;
    logic        hash_ready = 1'b0;
    logic [31:0] hash_value;

    // Shadow copy of the hash state, advanced on every accepted word.
    logic [31:0] acc_hash  = '0;
    logic [31:0] msg_bytes = '0;
    logic [31:0] pending_hashes[$];
    logic [31:0] expected_hash;
    dir_row_t    dir_rows[DIRECTED_ROWS];

    int unsigned cycle_count    = 0;
    int unsigned error_count    = 0;
    int unsigned hashes_checked = 0;
    int unsigned requests_sent  = 0;
    int unsigned burst_left     = 0;
    int unsigned stall_left     = 0;
    rx_mode_t    rx_mode        = RX_STREAM;

    murmur3_32_hash dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .data_word  (data_word),
        .byte_count (byte_count),
        .final_word (final_word),
        .hash_valid (hash_valid),
        .hash_ready (hash_ready),
        .hash_value (hash_value)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] scramble(logic [31:0] k);
        logic [31:0] t;
        t = k * MIX_MUL_A;
        t = {t[16:0], t[31:17]};
        return t * MIX_MUL_B;
    endfunction

    task automatic absorb_word(input logic [31:0] word, input logic [2:0] count,
                               input logic last, output bit done, output logic [31:0] digest);
        logic [2:0]  n;
        logic [31:0] h;
        logic [31:0] mask;
        // Only a last word may be short; anything above four counts as a full word.
        n = (count > 3'd4 || !last) ? 3'd4 : count;
        if (n == 3'd4)
        begin
            h = acc_hash ^ scramble(word);
            h = {h[18:0], h[31:19]};
            acc_hash = h * 32'd5 + FOLD_OFFSET;
        end
        else if (n != 3'd0)
        begin
            mask = 32'hffffffff >> (8 * (4 - n));
            acc_hash = acc_hash ^ scramble(word & mask);
        end
        msg_bytes = msg_bytes + n;
        done = last;
        digest = '0;
        if (last)
        begin
            h = acc_hash ^ msg_bytes;
            h = h ^ (h >> 16);
            h = h * AVAL_MUL_A;
            h = h ^ (h >> 13);
            h = h * AVAL_MUL_B;
            digest = h ^ (h >> 16);
            acc_hash = '0;
            msg_bytes = '0;
        end
    endtask

    // Called at a rising edge; returns at the edge where the request was taken,
    // or at the end of the idle gap that follows a burst.
    task automatic send_request(input logic [31:0] word, input logic [2:0] count,
                                input logic last, input chk_kind_t kind,
                                input logic [31:0] fixed_hash);
        bit          done;
        logic [31:0] digest;
        item_valid <= 1'b1;
        data_word  <= word;
        byte_count <= count;
        final_word <= last;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        absorb_word(word, count, last, done, digest);
        if (done)
            pending_hashes.insert(pending_hashes.size(),
                                  kind == CHK_FIXED ? fixed_hash : digest);
        requests_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            item_valid <= 1'b0;
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 5))
                @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 15))
            0: return 32'hffffffff;
            1: return 32'h00000000;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int unsigned words;
        int unsigned messages;
        int unsigned w;
        messages = 0;

        // An empty message after a clear hashes to zero, whatever the data lanes hold.
        dir_rows[0]  = '{32'h00000000, 3'd0, 1'b1, CHK_FIXED, 32'h00000000};
        dir_rows[1]  = '{32'hdeadbeef, 3'd0, 1'b1, CHK_FIXED, 32'h00000000};
        dir_rows[2]  = '{32'hffffffff, 3'd4, 1'b1, CHK_MODEL, 32'h0};
        dir_rows[3]  = '{32'h00000000, 3'd4, 1'b1, CHK_MODEL, 32'h0};
        dir_rows[4]  = '{32'h87654321, 3'd4, 1'b1, CHK_MODEL, 32'h0};
        dir_rows[5]  = '{32'hff654321, 3'd3, 1'b1, CHK_MODEL, 32'h0};
        dir_rows[6]  = '{32'hffff4321, 3'd2, 1'b1, CHK_MODEL, 32'h0};
        dir_rows[7]  = '{32'hffffff21, 3'd1, 1'b1, CHK_MODEL, 32'h0};
        dir_rows[8]  = '{32'h00ffffff, 3'd3, 1'b1, CHK_MODEL, 32'h0};
        dir_rows[9]  = '{32'h12345678, 3'd5, 1'b1, CHK_MODEL, 32'h0};
        dir_rows[10] = '{32'h9abcdef0, 3'd6, 1'b1, CHK_MODEL, 32'h0};
        dir_rows[11] = '{32'hffffffff, 3'd7, 1'b1, CHK_MODEL, 32'h0};
        // Short counts on words that are not last still take all four bytes.
        dir_rows[12] = '{32'h01234567, 3'd1, 1'b0, CHK_MODEL, 32'h0};
        dir_rows[13] = '{32'h89abcdef, 3'd0, 1'b0, CHK_MODEL, 32'h0};
        dir_rows[14] = '{32'hfedcba98, 3'd7, 1'b0, CHK_MODEL, 32'h0};
        dir_rows[15] = '{32'h00000000, 3'd0, 1'b1, CHK_MODEL, 32'h0};
        dir_rows[16] = '{32'ha5a5a5a5, 3'd4, 1'b0, CHK_MODEL, 32'h0};
        dir_rows[17] = '{32'h5a5a5a5a, 3'd4, 1'b0, CHK_MODEL, 32'h0};
        dir_rows[18] = '{32'hffffffff, 3'd4, 1'b0, CHK_MODEL, 32'h0};
        dir_rows[19] = '{32'h000000ff, 3'd1, 1'b1, CHK_MODEL, 32'h0};
        dir_rows[20] = '{32'hffffffff, 3'd4, 1'b0, CHK_MODEL, 32'h0};
        dir_rows[21] = '{32'hffffffff, 3'd4, 1'b1, CHK_MODEL, 32'h0};
        dir_rows[22] = '{32'h00000000, 3'd0, 1'b1, CHK_FIXED, 32'h00000000};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_request(dir_rows[i].word, dir_rows[i].count, dir_rows[i].last,
                         dir_rows[i].kind, dir_rows[i].fixed_hash);

        while (requests_sent < DIRECTED_ROWS + RANDOM_REQUESTS)
        begin
            words = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 16) : $urandom_range(0, 3);
            for (w = 0; w < words; w++)
                send_request(random_word(),
                             ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'd4,
                             1'b0, CHK_MODEL, 32'h0);
            send_request(random_word(), 3'($urandom_range(0, 7)), 1'b1, CHK_MODEL, 32'h0);
            messages++;
        end
        item_valid <= 1'b0;

        while (pending_hashes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests: %0d directed rows and %0d random messages.",
                 requests_sent, DIRECTED_ROWS, messages);
        $display("Checked %0d hashes in %0d cycles with %0d mismatches.",
                 hashes_checked, cycle_count, error_count);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;

        if (hash_valid && hash_ready)
        begin
            if (pending_hashes.size() == 0)
            begin
                $error("hash_value with no message pending: expected none, actual %h",
                       hash_value);
                error_count++;
            end
            else
            begin
                expected_hash = pending_hashes.pop_front();
                if (hash_value !== expected_hash)
                begin
                    $error("hash_value mismatch: expected %h, actual %h",
                           expected_hash, hash_value);
                    error_count++;
                end
                hashes_checked++;
            end
        end

        // The receiver drops ready for a counted stall, then raises it again.
        if (stall_left != 0)
        begin
            hash_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            hash_ready <= 1'b1;
            case (rx_mode)
                RX_STREAM: stall_left <= 0;
                RX_CHOPPY: stall_left <= $urandom_range(0, 2);
                default:   stall_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : 0;
            endcase
        end
        if (cycle_count % 300 == 0)
            rx_mode <= rx_mode_t'($urandom_range(0, 2));

        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule
